// ===== design/pcpf_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpf_pkg
// Shared types and fixed field widths for the pulser centroid peak finder.
// ----------------------------------------------------------------------------
package pcpf_pkg;

  localparam int unsigned VAL_W  = 10;
  localparam int unsigned AMP_W  = 19;
  localparam int unsigned WSUM_W = 27;
  localparam int unsigned CENT_W = 17;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned CNT_W  = 8;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_SAMPLE  = 2'd1,
    KIND_PAD_END = 2'd2
  } kind_e;

  typedef enum logic {
    REG_EXP_POS  = 1'b0,
    REG_MAX_DIST = 1'b1
  } reg_idx_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ACC  = 6'b000100,
    ST_PRE  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_CMP  = 6'b100000
  } state_e;

endpackage

// ===== design/pulser_centroid_peak_finder_top.sv =====
// ----------------------------------------------------------------------------
// pulser_centroid_peak_finder_top
// Per-pad pulser search over weighted centroids of zero-suppressed sequences.
// ----------------------------------------------------------------------------
// Table loads and pad-end beats leave the block idle. A sample beat passes through
// table read, multiply and accumulate, and no new beat is taken until it is through.
// A sample that ends a sequence adds a set-up step: a zero amplitude ends there,
// a saturating centroid goes straight to the distance compare, and any other
// sequence runs a restoring divider that produces one quotient bit per cycle,
// 17 bits in all, followed by the distance compare. A pad-end beat waits while a
// sample is in progress or while the previous result is held and not taken.
module pulser_centroid_peak_finder_top #(
  parameter int unsigned TIME_BINS = 512,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  table_index_i,
  input  logic [9:0]  table_value_i,
  input  logic [7:0]  adc_code_i,
  input  logic [8:0]  time_bin_i,
  input  logic        seq_last_i,
  input  logic [7:0]  pad_id_i,
  input  logic [5:0]  row_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_pad_o,
  output logic [5:0]  out_row_o,
  output logic        found_o,
  output logic [18:0] peak_amplitude_o,
  output logic [16:0] peak_centroid_o,
  output logic [7:0]  sequence_count_o
);

  localparam int unsigned VAL_W  = pcpf_pkg::VAL_W;
  localparam int unsigned AMP_W  = pcpf_pkg::AMP_W;
  localparam int unsigned WSUM_W = pcpf_pkg::WSUM_W;
  localparam int unsigned CENT_W = pcpf_pkg::CENT_W;
  localparam int unsigned POS_W  = pcpf_pkg::POS_W;
  localparam int unsigned CNT_W  = pcpf_pkg::CNT_W;
  localparam int unsigned TB_W   = $clog2(TIME_BINS);
  localparam int unsigned T_W    = (TB_W > POS_W) ? TB_W : POS_W;
  localparam int unsigned PROD_W = VAL_W + T_W;
  localparam int unsigned NUM_W  = WSUM_W + FRAC_BITS;
  localparam int unsigned TOP_W  = NUM_W - CENT_W;
  localparam int unsigned CMPW   = ((TOP_W > AMP_W) ? TOP_W : AMP_W) + 1;
  localparam int unsigned E_W    = POS_W + FRAC_BITS;
  localparam int unsigned DW     = ((E_W > CENT_W) ? E_W : CENT_W) + 1;
  localparam int unsigned STEP_W = $clog2(CENT_W);

  pcpf_pkg::state_e state_q, state_d;

  logic [VAL_W-1:0]  mem [256];
  logic [VAL_W-1:0]  rd_q;
  logic [T_W-1:0]    t_q;
  logic              last_q;
  logic [PROD_W-1:0] prod_q;

  logic [POS_W-1:0]  exp_q, maxd_q;
  logic [AMP_W-1:0]  amp_q, best_amp_q;
  logic [WSUM_W-1:0] wsum_q;
  logic [CENT_W-1:0] best_dist_q, best_cent_q;
  logic              found_q;
  logic [CNT_W-1:0]  seq_cnt_q;

  logic [AMP_W-1:0]  rem_q, rem_d;
  logic [CENT_W-1:0] low_q, low_d;
  logic [STEP_W-1:0] step_q;

  logic              out_valid_q;
  logic [7:0]        out_pad_q;
  logic [5:0]        out_row_q;
  logic              out_found_q;
  logic [AMP_W-1:0]  out_amp_q;
  logic [CENT_W-1:0] out_cent_q;
  logic [CNT_W-1:0]  out_cnt_q;

  logic              in_acc, is_load, is_sample, is_end;
  logic [T_W-1:0]    t_lim, t_in, t_clamped;
  logic [AMP_W:0]    amp_sum;
  logic [WSUM_W:0]   wsum_sum;
  logic [AMP_W-1:0]  amp_next;
  logic [WSUM_W-1:0] wsum_next;
  logic [NUM_W-1:0]  num;
  logic              div_ovf;
  logic [AMP_W:0]    trial;
  logic              ge;
  logic [DW-1:0]     c_ext, e_ext, diff, md_ext;
  logic [CENT_W-1:0] seq_dist, start_dist;

  function automatic logic [CENT_W-1:0] sat_cent(input logic [DW-1:0] v);
    sat_cent = (|v[DW-1:CENT_W]) ? {CENT_W{1'b1}} : v[CENT_W-1:0];
  endfunction

  assign is_load   = (kind_i == pcpf_pkg::KIND_LOAD);
  assign is_sample = (kind_i == pcpf_pkg::KIND_SAMPLE);
  assign is_end    = (kind_i == pcpf_pkg::KIND_PAD_END);

  assign in_ready_o = (state_q == pcpf_pkg::ST_IDLE) &&
                      (!is_end || !out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  assign t_lim     = T_W'(TIME_BINS - 1);
  assign t_in      = T_W'(time_bin_i);
  assign t_clamped = (t_in > t_lim) ? t_lim : t_in;

  assign amp_sum   = {1'b0, amp_q} + (AMP_W + 1)'(rd_q);
  assign amp_next  = amp_sum[AMP_W] ? {AMP_W{1'b1}} : amp_sum[AMP_W-1:0];
  assign wsum_sum  = {1'b0, wsum_q} + (WSUM_W + 1)'(prod_q);
  assign wsum_next = wsum_sum[WSUM_W] ? {WSUM_W{1'b1}} : wsum_sum[WSUM_W-1:0];

  assign num     = NUM_W'(wsum_q) << FRAC_BITS;
  assign div_ovf = CMPW'(num[NUM_W-1:CENT_W]) >= CMPW'(amp_q);

  assign trial = {rem_q, low_q[CENT_W-1]};
  assign ge    = trial >= {1'b0, amp_q};
  assign rem_d = ge ? AMP_W'(trial - {1'b0, amp_q}) : trial[AMP_W-1:0];
  assign low_d = {low_q[CENT_W-2:0], ge};

  assign c_ext      = DW'(low_q);
  assign e_ext      = DW'(exp_q) << FRAC_BITS;
  assign diff       = (c_ext >= e_ext) ? (c_ext - e_ext) : (e_ext - c_ext);
  assign seq_dist   = sat_cent(diff);
  assign md_ext     = DW'(maxd_q) << FRAC_BITS;
  assign start_dist = sat_cent(md_ext);

  always_comb begin
    state_d = state_q;
    case (state_q)
      pcpf_pkg::ST_IDLE: if (in_acc && is_sample) state_d = pcpf_pkg::ST_MUL;
      pcpf_pkg::ST_MUL:  state_d = pcpf_pkg::ST_ACC;
      pcpf_pkg::ST_ACC:  state_d = last_q ? pcpf_pkg::ST_PRE : pcpf_pkg::ST_IDLE;
      pcpf_pkg::ST_PRE: begin
        if (amp_q == '0) begin
          state_d = pcpf_pkg::ST_IDLE;
        end else if (div_ovf) begin
          state_d = pcpf_pkg::ST_CMP;
        end else begin
          state_d = pcpf_pkg::ST_DIV;
        end
      end
      pcpf_pkg::ST_DIV: begin
        if (step_q == STEP_W'(CENT_W - 1)) state_d = pcpf_pkg::ST_CMP;
      end
      pcpf_pkg::ST_CMP:  state_d = pcpf_pkg::ST_IDLE;
      default:           state_d = pcpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_load) begin
      mem[table_index_i] <= table_value_i;
    end
    if (in_acc && is_sample) begin
      rd_q   <= mem[adc_code_i];
      t_q    <= t_clamped;
      last_q <= seq_last_i;
    end
    if (state_q == pcpf_pkg::ST_MUL) begin
      prod_q <= rd_q * t_q;
    end
    case (state_q)
      pcpf_pkg::ST_PRE: begin
        rem_q  <= AMP_W'(num[NUM_W-1:CENT_W]);
        low_q  <= div_ovf ? {CENT_W{1'b1}} : num[CENT_W-1:0];
        step_q <= '0;
      end
      pcpf_pkg::ST_DIV: begin
        rem_q  <= rem_d;
        low_q  <= low_d;
        step_q <= step_q + STEP_W'(1);
      end
      default: ;
    endcase
    if (in_acc && is_end) begin
      out_pad_q   <= pad_id_i;
      out_row_q   <= row_id_i;
      out_found_q <= found_q;
      out_amp_q   <= found_q ? best_amp_q : '0;
      out_cent_q  <= found_q ? best_cent_q : '0;
      out_cnt_q   <= seq_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcpf_pkg::ST_IDLE;
      exp_q       <= '0;
      maxd_q      <= '0;
      amp_q       <= '0;
      wsum_q      <= '0;
      best_dist_q <= '0;
      best_amp_q  <= '0;
      best_cent_q <= '0;
      found_q     <= 1'b0;
      seq_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        pcpf_pkg::ST_ACC: begin
          amp_q  <= amp_next;
          wsum_q <= wsum_next;
        end
        pcpf_pkg::ST_PRE: begin
          if (seq_cnt_q != {CNT_W{1'b1}}) seq_cnt_q <= seq_cnt_q + CNT_W'(1);
          if (amp_q == '0) wsum_q <= '0;
        end
        pcpf_pkg::ST_CMP: begin
          if (seq_dist < best_dist_q) begin
            found_q     <= 1'b1;
            best_amp_q  <= amp_q;
            best_cent_q <= low_q;
            best_dist_q <= seq_dist;
          end
          amp_q  <= '0;
          wsum_q <= '0;
        end
        default: ;
      endcase
      if (in_acc && is_end) begin
        out_valid_q <= 1'b1;
        amp_q       <= '0;
        wsum_q      <= '0;
        found_q     <= 1'b0;
        best_amp_q  <= '0;
        best_cent_q <= '0;
        seq_cnt_q   <= '0;
        best_dist_q <= start_dist;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pcpf_pkg::REG_EXP_POS: exp_q <= cfg_data_i;
          pcpf_pkg::REG_MAX_DIST: begin
            maxd_q <= cfg_data_i;
            if (!found_q) best_dist_q <= sat_cent(DW'(cfg_data_i) << FRAC_BITS);
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_pad_o        = out_pad_q;
  assign out_row_o        = out_row_q;
  assign found_o          = out_found_q;
  assign peak_amplitude_o = out_amp_q;
  assign peak_centroid_o  = out_cent_q;
  assign sequence_count_o = out_cnt_q;

endmodule

// ===== sim/pulser_centroid_peak_finder_top_tb.sv =====
// ----------------------------------------------------------------------------
// pulser_centroid_peak_finder_top_tb
// Drives table loads, sample sequences and pad ends into the peak finder.
// Configuration changes between traffic phases, some of them in mid-pad. A
// centroid scoreboard keeps its own table, sums and best-sequence search and
// checks every result beat field by field, in order. Both handshakes idle at
// random, and the result side holds off once for long enough to block input.
// ----------------------------------------------------------------------------
localparam int unsigned BINS = 512;
localparam int unsigned FRAC = 8;
localparam longint unsigned AMP_SAT  = (64'd1 << pcpf_pkg::AMP_W) - 64'd1;
localparam longint unsigned WSUM_SAT = (64'd1 << pcpf_pkg::WSUM_W) - 64'd1;
localparam longint unsigned CENT_SAT = (64'd1 << pcpf_pkg::CENT_W) - 64'd1;
localparam logic [1:0] KIND_SPARE = 2'd3;

typedef struct {
  logic [1:0] kind;
  logic [7:0] index;
  logic [9:0] value;
  logic [7:0] code;
  logic [8:0] tbin;
  logic       seq_last;
  logic [7:0] pad;
  logic [5:0] row;
} beat_t;

typedef struct {
  logic [7:0]                  pad;
  logic [5:0]                  row;
  logic                        found;
  logic [pcpf_pkg::AMP_W-1:0]  amp;
  logic [pcpf_pkg::CENT_W-1:0] cent;
  logic [pcpf_pkg::CNT_W-1:0]  count;
} pad_result_t;

class centroid_scoreboard;
  logic [pcpf_pkg::VAL_W-1:0]  lut [256];
  logic [pcpf_pkg::POS_W-1:0]  exp_pos;
  logic [pcpf_pkg::POS_W-1:0]  max_dist;
  logic [pcpf_pkg::AMP_W-1:0]  amp_acc;
  logic [pcpf_pkg::AMP_W-1:0]  best_amp;
  logic [pcpf_pkg::WSUM_W-1:0] wsum_acc;
  logic [pcpf_pkg::CENT_W-1:0] best_dist;
  logic [pcpf_pkg::CENT_W-1:0] best_cent;
  logic [pcpf_pkg::CNT_W-1:0]  seq_cnt;
  bit                          found;
  pad_result_t                 expected_q [$];
  int unsigned                 mismatches;
  int unsigned                 checked;

  function new();
    foreach (lut[i]) lut[i] = '0;
    exp_pos    = '0;
    max_dist   = '0;
    mismatches = 0;
    checked    = 0;
    clear_pad();
  endfunction

  function logic [pcpf_pkg::CENT_W-1:0] window();
    longint unsigned d;
    d = max_dist;
    d = d << FRAC;
    if (d > CENT_SAT) d = CENT_SAT;
    return pcpf_pkg::CENT_W'(d);
  endfunction

  function void clear_pad();
    amp_acc   = '0;
    wsum_acc  = '0;
    found     = 1'b0;
    best_amp  = '0;
    best_cent = '0;
    seq_cnt   = '0;
    best_dist = window();
  endfunction

  function void set_reg(pcpf_pkg::reg_idx_e idx, logic [pcpf_pkg::POS_W-1:0] val);
    if (idx == pcpf_pkg::REG_EXP_POS) begin
      exp_pos = val;
    end else begin
      max_dist = val;
      if (!found) best_dist = window();
    end
  endfunction

  function void close_seq();
    longint unsigned c;
    longint unsigned e;
    longint unsigned d;
    if (seq_cnt != '1) seq_cnt++;
    if (amp_acc != '0) begin
      c = wsum_acc;
      c = (c << FRAC) / amp_acc;
      if (c > CENT_SAT) c = CENT_SAT;
      e = exp_pos;
      e = e << FRAC;
      d = (c >= e) ? c - e : e - c;
      if (d > CENT_SAT) d = CENT_SAT;
      if (d < best_dist) begin
        found     = 1'b1;
        best_amp  = amp_acc;
        best_cent = pcpf_pkg::CENT_W'(c);
        best_dist = pcpf_pkg::CENT_W'(d);
      end
    end
    amp_acc  = '0;
    wsum_acc = '0;
  endfunction

  function void note_beat(beat_t b);
    longint unsigned v;
    longint unsigned t;
    longint unsigned a;
    longint unsigned w;
    pad_result_t     r;
    case (b.kind)
      pcpf_pkg::KIND_LOAD: begin
        lut[b.index] = b.value;
      end
      pcpf_pkg::KIND_SAMPLE: begin
        v = lut[b.code];
        t = b.tbin;
        if (t > BINS - 1) t = BINS - 1;
        a = amp_acc;
        a = a + v;
        if (a > AMP_SAT) a = AMP_SAT;
        amp_acc = pcpf_pkg::AMP_W'(a);
        w = wsum_acc;
        w = w + v * t;
        if (w > WSUM_SAT) w = WSUM_SAT;
        wsum_acc = pcpf_pkg::WSUM_W'(w);
        if (b.seq_last) close_seq();
      end
      pcpf_pkg::KIND_PAD_END: begin
        r.pad   = b.pad;
        r.row   = b.row;
        r.found = found;
        r.amp   = found ? best_amp : '0;
        r.cent  = found ? best_cent : '0;
        r.count = seq_cnt;
        expected_q.push_back(r);
        clear_pad();
      end
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  task report(string what);
    if (mismatches < 100) $display("result %0d: %s", checked, what);
    mismatches++;
  endtask

  task compare(string name, longint unsigned got, longint unsigned want);
    if (got != want) report($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  task check_result(pad_result_t got);
    pad_result_t want;
    checked++;
    if (expected_q.size() == 0) begin
      report("result beat with no pad end pending");
    end else begin
      want = expected_q.pop_front();
      compare("out_pad", got.pad, want.pad);
      compare("out_row", got.row, want.row);
      compare("found", got.found, want.found);
      compare("peak_amplitude", got.amp, want.amp);
      compare("peak_centroid", got.cent, want.cent);
      compare("sequence_count", got.count, want.count);
    end
  endtask
endclass

module pulser_centroid_peak_finder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEMS        = 1850;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_AFTER   = 40;
  localparam int unsigned HOLD_CYCLES  = 1200;
  localparam int unsigned STALL_LIMIT  = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [8:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [7:0]  table_index_i;
  logic [9:0]  table_value_i;
  logic [7:0]  adc_code_i;
  logic [8:0]  time_bin_i;
  logic        seq_last_i;
  logic [7:0]  pad_id_i;
  logic [5:0]  row_id_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_pad_o;
  logic [5:0]  out_row_o;
  logic        found_o;
  logic [18:0] peak_amplitude_o;
  logic [16:0] peak_centroid_o;
  logic [7:0]  sequence_count_o;

  centroid_scoreboard sb = new();

  int unsigned sent;
  int unsigned calm_left;
  logic [8:0]  cur_pos;
  logic [8:0]  cur_dist;
  bit          written [256];
  logic [7:0]  codes [$];

  pulser_centroid_peak_finder_top #(
    .TIME_BINS(BINS),
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .table_index_i    (table_index_i),
    .table_value_i    (table_value_i),
    .adc_code_i       (adc_code_i),
    .time_bin_i       (time_bin_i),
    .seq_last_i       (seq_last_i),
    .pad_id_i         (pad_id_i),
    .row_id_i         (row_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_pad_o        (out_pad_o),
    .out_row_o        (out_row_o),
    .found_o          (found_o),
    .peak_amplitude_o (peak_amplitude_o),
    .peak_centroid_o  (peak_centroid_o),
    .sequence_count_o (sequence_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic beat_t rand_beat();
    beat_t b;
    b.kind     = KIND_SPARE;
    b.index    = 8'($urandom);
    b.value    = 10'($urandom);
    b.code     = 8'($urandom);
    b.tbin     = 9'($urandom);
    b.seq_last = 1'($urandom);
    b.pad      = 8'($urandom);
    b.row      = 6'($urandom);
    return b;
  endfunction

  task automatic idle_sender();
    int unsigned r;
    int unsigned gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (calm_left != 0) calm_left--;
    else if (r < 3) calm_left = $urandom_range(20, 80);
    else if (r < 55) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send(beat_t b);
    in_valid_i    <= 1'b1;
    kind_i        <= b.kind;
    table_index_i <= b.index;
    table_value_i <= b.value;
    adc_code_i    <= b.code;
    time_bin_i    <= b.tbin;
    seq_last_i    <= b.seq_last;
    pad_id_i      <= b.pad;
    row_id_i      <= b.row;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_beat(b);
    if (b.kind != KIND_SPARE) sent++;
    idle_sender();
  endtask

  task automatic load(logic [7:0] idx, logic [9:0] val);
    beat_t b;
    b       = rand_beat();
    b.kind  = pcpf_pkg::KIND_LOAD;
    b.index = idx;
    b.value = val;
    if (!written[idx]) begin
      written[idx] = 1'b1;
      codes.push_back(idx);
    end
    send(b);
  endtask

  task automatic sample(logic [7:0] code, logic [8:0] tbin, logic last);
    beat_t b;
    b          = rand_beat();
    b.kind     = pcpf_pkg::KIND_SAMPLE;
    b.code     = code;
    b.tbin     = tbin;
    b.seq_last = last;
    send(b);
  endtask

  task automatic pad_end(logic [7:0] pad, logic [5:0] row);
    beat_t b;
    b      = rand_beat();
    b.kind = pcpf_pkg::KIND_PAD_END;
    b.pad  = pad;
    b.row  = row;
    send(b);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(pcpf_pkg::reg_idx_e idx, logic [8:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == pcpf_pkg::REG_EXP_POS) cur_pos = val;
    else cur_dist = val;
  endtask

  task automatic send_pad(bit closed);
    int unsigned n_seq;
    int unsigned len;
    int          spread;
    int          centre;
    int          tb;
    bit          mute;
    bit          open_tail;
    beat_t       b;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 7))
          0: load(8'($urandom_range(1, 255)), 10'd0);
          1: load(8'($urandom_range(1, 255)), 10'd1023);
          default: load(8'($urandom_range(1, 255)), 10'($urandom));
        endcase
      end
    end
    n_seq = $urandom_range(0, 6);
    for (int s = 0; s < n_seq; s++) begin
      mute      = ($urandom_range(0, 7) == 0);
      len       = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
      spread    = int'(cur_dist) + 6;
      centre    = int'($urandom_range(0, 2 * spread)) - spread + int'(cur_pos);
      open_tail = closed && (s == n_seq - 1) && ($urandom_range(0, 9) == 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 24) == 0) begin
          b = rand_beat();
          send(b);
        end
        if ($urandom_range(0, 9) == 0) tb = int'($urandom_range(0, 511));
        else tb = centre + int'($urandom_range(0, 6)) - 3;
        if (tb < 0) tb = 0;
        if (tb > 511) tb = 511;
        sample(mute ? 8'd0 : codes[$urandom_range(0, codes.size() - 1)], 9'(tb),
               (k == len - 1) && !open_tail);
      end
    end
    if (closed) pad_end(8'($urandom), 6'($urandom));
  endtask

  always @(posedge clk_i) begin
    pad_result_t r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      r.pad   = out_pad_o;
      r.row   = out_row_o;
      r.found = found_o;
      r.amp   = peak_amplitude_o;
      r.cent  = peak_centroid_o;
      r.count = sequence_count_o;
      sb.check_result(r);
    end
  end

  initial begin : result_side
    int unsigned r;
    int unsigned span;
    bit          lvl;
    bit          held;
    held = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && sb.checked >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        lvl  = 1'b1;
        span = $urandom_range(1, 8);
      end else if (r < 85) begin
        lvl  = 1'b0;
        span = $urandom_range(1, 3);
      end else if (r < 95) begin
        lvl  = 1'b0;
        span = $urandom_range(4, 15);
      end else if (r < 97) begin
        lvl  = 1'b0;
        span = $urandom_range(30, 80);
      end else begin
        lvl  = 1'b1;
        span = $urandom_range(100, 300);
      end
      out_ready_i <= lvl;
      repeat (span) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("pulser_centroid_peak_finder_top verification failed");
    $finish;
  end

  initial begin : stimulus
    beat_t       b;
    int unsigned phase;
    int unsigned phase_start;
    logic [8:0]  pos;
    logic [8:0]  max_d;
    sent      = 0;
    calm_left = 0;
    cur_pos   = '0;
    cur_dist  = '0;
    foreach (written[i]) written[i] = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= pcpf_pkg::REG_EXP_POS;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    kind_i        <= pcpf_pkg::KIND_LOAD;
    table_index_i <= '0;
    table_value_i <= '0;
    adc_code_i    <= '0;
    time_bin_i    <= '0;
    seq_last_i    <= 1'b0;
    pad_id_i      <= '0;
    row_id_i      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(pcpf_pkg::REG_EXP_POS, 9'd100);
    write_reg(pcpf_pkg::REG_MAX_DIST, 9'd8);
    load(8'd0, 10'd0);
    load(8'd255, 10'd1023);
    load(8'd1, 10'd512);
    load(8'h5a, 10'h2a5);
    b = rand_beat();
    send(b);
    sample(8'd0, 9'd100, 1'b1);
    sample(8'd255, 9'd99, 1'b0);
    sample(8'd1, 9'd101, 1'b1);
    sample(8'd255, 9'd100, 1'b1);
    sample(8'd255, 9'd100, 1'b1);
    pad_end(8'd255, 6'd63);
    pad_end(8'd0, 6'd0);
    sample(8'd255, 9'd511, 1'b1);
    sample(8'd1, 9'd0, 1'b0);
    pad_end(8'($urandom), 6'($urandom));
    // widen the window with nothing found, then narrow it with a sequence held
    sample(8'd255, 9'd511, 1'b1);
    settle();
    write_reg(pcpf_pkg::REG_MAX_DIST, 9'd511);
    sample(8'd1, 9'd400, 1'b1);
    settle();
    write_reg(pcpf_pkg::REG_MAX_DIST, 9'd0);
    sample(8'd1, 9'd300, 1'b1);
    pad_end(8'($urandom), 6'($urandom));

    phase = 0;
    while (sent < ITEMS) begin
      settle();
      case (phase)
        0: begin pos = 9'd0;   max_d = 9'd0;   end
        1: begin pos = 9'd511; max_d = 9'd511; end
        2: begin pos = 9'd256; max_d = 9'd4;   end
        3: begin pos = 9'd511; max_d = 9'd0;   end
        4: begin pos = 9'd0;   max_d = 9'd511; end
        default: begin
          pos   = 9'($urandom_range(0, 511));
          max_d = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                              : 9'($urandom_range(0, 24));
        end
      endcase
      write_reg(pcpf_pkg::REG_EXP_POS, pos);
      write_reg(pcpf_pkg::REG_MAX_DIST, max_d);
      phase_start = sent;
      if (phase == 2) begin
        // saturate both sums in one long sequence
        load(8'd255, 10'd1023);
        for (int k = 0; k < 520; k++) sample(8'd255, 9'($urandom_range(300, 511)), k == 519);
        pad_end(8'($urandom), 6'($urandom));
      end
      if (phase == 5) begin
        // saturate the sequence count
        repeat (262) begin
          sample(($urandom_range(0, 3) == 0) ? codes[$urandom_range(0, codes.size() - 1)] : 8'd0,
                 9'($urandom_range(0, 511)), 1'b1);
        end
        pad_end(8'($urandom), 6'($urandom));
      end
      while (sent - phase_start < PHASE_ITEMS) send_pad(1'b1);
      if ($urandom_range(0, 2) == 0) send_pad(1'b0);
      phase++;
    end
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("pulser_centroid_peak_finder_top verification clean");
    end else begin
      $display("pulser_centroid_peak_finder_top verification failed");
    end
    $finish;
  end

endmodule
